@@ rtl/core/oom_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oom_pkg
// Shared types and register indexes for the output overvoltage and
// overcurrent monitor.
// ----------------------------------------------------------------------------
package oom_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OVP_MARGIN_NORMAL  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVP_MARGIN_DIGITAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVP_HARD_MARGIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_SOFT_MARGIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_HARD_MARGIN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_ABS_LIMIT      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCP_MARGIN         = 3'd6;

   localparam logic [15:0] OVP_MARGIN_NORMAL_RST  = 16'd500;
   localparam logic [15:0] OVP_MARGIN_DIGITAL_RST = 16'd1000;
   localparam logic [15:0] OVP_HARD_MARGIN_RST    = 16'd2000;
   localparam logic [15:0] PRE_SOFT_MARGIN_RST    = 16'd300;
   localparam logic [15:0] PRE_HARD_MARGIN_RST    = 16'd1500;
   localparam logic [15:0] PRE_ABS_LIMIT_RST      = 16'd0;
   localparam logic [15:0] OCP_MARGIN_RST         = 16'd500;

   typedef struct packed {
      logic               restart;
      logic        [15:0] vout_mv;
      logic signed [15:0] iout_ma;
      logic        [15:0] iref_ma;
      logic        [15:0] vtarget_mv;
      logic               digital_mode;
      logic               preconnect;
      logic               handover;
   } req_type;

   typedef struct packed {
      logic ovp_trip;
      logic ovp_hard;
      logic ocp_trip;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ovp_margin_normal_mv;
      logic [15:0] ovp_margin_digital_mv;
      logic [15:0] ovp_hard_margin_mv;
      logic [15:0] pre_soft_margin_mv;
      logic [15:0] pre_hard_margin_mv;
      logic [15:0] pre_abs_limit_mv;
      logic [15:0] ocp_margin_ma;
   } cfg_type;

   typedef struct packed {
      logic [7:0] blank_left;
      logic [7:0] ovp_run;
      logic [7:0] ocp_run;
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/oom_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oom_eval
// Limit calculation, comparisons and confirm counter update for one sample.
// ----------------------------------------------------------------------------
module oom_eval #(
   parameter int unsigned BLANK_SAMPLES = 16,
   parameter int unsigned OVP_CONFIRM   = 4,
   parameter int unsigned OCP_CONFIRM   = 4
) (
   input  wire oom_pkg::req_type   req,
   input  wire oom_pkg::cfg_type   cfg,
   input  wire oom_pkg::state_type state_cur,
   output oom_pkg::rsp_type        rsp,
   output oom_pkg::state_type      state_nxt
);

   localparam logic [7:0] BLANK_INIT = 8'(BLANK_SAMPLES);
   localparam logic [7:0] OVP_CONF   = 8'(OVP_CONFIRM);
   localparam logic [7:0] OCP_CONF   = 8'(OCP_CONFIRM);

   logic [7:0]  blank_dec;
   logic [16:0] soft_lim;
   logic [16:0] hard_lim;
   logic [16:0] ocp_lim;
   logic [16:0] vout_ext;
   logic [16:0] icur;
   logic [7:0]  ovp_inc;
   logic [7:0]  ocp_inc;

   always_comb begin
      blank_dec = (state_cur.blank_left != 8'd0) ? state_cur.blank_left - 8'd1 : 8'd0;
      if (req.preconnect) begin
         soft_lim = (cfg.pre_abs_limit_mv != 16'd0) ? {1'b0, cfg.pre_abs_limit_mv}
                  : {1'b0, req.vtarget_mv} + {1'b0, cfg.pre_soft_margin_mv};
         hard_lim = {1'b0, req.vtarget_mv} + {1'b0, cfg.pre_hard_margin_mv};
      end else begin
         soft_lim = {1'b0, req.vtarget_mv} + (req.digital_mode
                  ? {1'b0, cfg.ovp_margin_digital_mv} : {1'b0, cfg.ovp_margin_normal_mv});
         hard_lim = {1'b0, req.vtarget_mv} + {1'b0, cfg.ovp_hard_margin_mv};
      end
      ocp_lim  = {1'b0, req.iref_ma} + {1'b0, cfg.ocp_margin_ma};
      vout_ext = {1'b0, req.vout_mv};
      icur     = req.iout_ma[15] ? 17'd0 : {2'b00, req.iout_ma[14:0]};
      ovp_inc  = (state_cur.ovp_run < OVP_CONF) ? state_cur.ovp_run + 8'd1
                                                 : state_cur.ovp_run;
      ocp_inc  = (state_cur.ocp_run < OCP_CONF) ? state_cur.ocp_run + 8'd1
                                                 : state_cur.ocp_run;

      rsp                  = '0;
      state_nxt            = state_cur;
      state_nxt.blank_left = blank_dec;

      if (req.restart) begin
         state_nxt.blank_left = BLANK_INIT;
         state_nxt.ovp_run    = 8'd0;
         state_nxt.ocp_run    = 8'd0;
      end else begin
         if (vout_ext > hard_lim) begin
            rsp.ovp_hard      = 1'b1;
            rsp.ovp_trip      = 1'b1;
            state_nxt.ovp_run = OVP_CONF;
         end else if (vout_ext <= soft_lim || blank_dec != 8'd0) begin
            state_nxt.ovp_run = 8'd0;
         end else begin
            state_nxt.ovp_run = ovp_inc;
            rsp.ovp_trip      = (ovp_inc >= OVP_CONF);
         end

         if (icur <= ocp_lim) begin
            state_nxt.ocp_run = 8'd0;
         end else if (!req.preconnect && !req.handover) begin
            rsp.ocp_trip = 1'b1;
         end else begin
            state_nxt.ocp_run = ocp_inc;
            rsp.ocp_trip      = (ocp_inc >= OCP_CONF);
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/output_ovp_ocp_monitor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// output_ovp_ocp_monitor
// Output overvoltage and overcurrent monitor with blanking and confirm counters.
// ----------------------------------------------------------------------------
// One request is one control-tick sample of the charger output and gives one
// response with the overvoltage and overcurrent flags. A request is taken into
// an input register, checked against the soft, hard and current limits and
// written to a response register; a new request is accepted every cycle while
// the response side keeps up. Configuration writes are registered, and the user
// is to make them only while the block is idle; the block does not enforce this.
module output_ovp_ocp_monitor #(
   parameter int unsigned BLANK_SAMPLES = 16,
   parameter int unsigned OVP_CONFIRM   = 4,
   parameter int unsigned OCP_CONFIRM   = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire oom_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output oom_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire [oom_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [oom_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic [7:0] BLANK_INIT = 8'(BLANK_SAMPLES);

   oom_pkg::cfg_type   cfg_ff,   cfg_in;
   oom_pkg::state_type state_ff, state_in;
   oom_pkg::req_type   req_ff;
   oom_pkg::rsp_type   rsp_ff,   rsp_in;
   logic               req_vld_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               advance;

   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);

   oom_eval #(
      .BLANK_SAMPLES (BLANK_SAMPLES),
      .OVP_CONFIRM   (OVP_CONFIRM),
      .OCP_CONFIRM   (OCP_CONFIRM)
   ) u_eval (
      .req       (req_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .rsp       (rsp_in),
      .state_nxt (state_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            oom_pkg::CSR_OVP_MARGIN_NORMAL:  cfg_in.ovp_margin_normal_mv  = csr_wdata;
            oom_pkg::CSR_OVP_MARGIN_DIGITAL: cfg_in.ovp_margin_digital_mv = csr_wdata;
            oom_pkg::CSR_OVP_HARD_MARGIN:    cfg_in.ovp_hard_margin_mv    = csr_wdata;
            oom_pkg::CSR_PRE_SOFT_MARGIN:    cfg_in.pre_soft_margin_mv    = csr_wdata;
            oom_pkg::CSR_PRE_HARD_MARGIN:    cfg_in.pre_hard_margin_mv    = csr_wdata;
            oom_pkg::CSR_PRE_ABS_LIMIT:      cfg_in.pre_abs_limit_mv      = csr_wdata;
            oom_pkg::CSR_OCP_MARGIN:         cfg_in.ocp_margin_ma         = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ovp_margin_normal_mv  <= oom_pkg::OVP_MARGIN_NORMAL_RST;
         cfg_ff.ovp_margin_digital_mv <= oom_pkg::OVP_MARGIN_DIGITAL_RST;
         cfg_ff.ovp_hard_margin_mv    <= oom_pkg::OVP_HARD_MARGIN_RST;
         cfg_ff.pre_soft_margin_mv    <= oom_pkg::PRE_SOFT_MARGIN_RST;
         cfg_ff.pre_hard_margin_mv    <= oom_pkg::PRE_HARD_MARGIN_RST;
         cfg_ff.pre_abs_limit_mv      <= oom_pkg::PRE_ABS_LIMIT_RST;
         cfg_ff.ocp_margin_ma         <= oom_pkg::OCP_MARGIN_RST;
         state_ff.blank_left          <= BLANK_INIT;
         state_ff.ovp_run             <= 8'd0;
         state_ff.ocp_run             <= 8'd0;
         req_vld_ff                   <= 1'b0;
         rsp_vld_ff                   <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         rsp_vld_ff <= rsp_vld_in;
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
